/* rtl/core/rsi_pkg.sv */
// rsi_pkg: shared types and constants of the relative strength index unit
// holds payload structs, divider command/status structs and the sequencer states
// no dependencies
package rsi_pkg;

   localparam int PRICE_W = 32;
   localparam int AVG_W   = 48;
   localparam int DIV_W   = 49;
   localparam int QUO_W   = 40;
   localparam int RSI_W   = 15;
   localparam int STEP_W  = 6;
   localparam int PROD_W  = 63;
   localparam int PER_W   = 8;

   // count value that marks the averages as formed
   localparam logic [PER_W-1:0] COUNT_DONE = 8'd255;
   // 100.0 with eight fraction bits
   localparam logic [RSI_W-1:0] RSI_SCALE = 15'd25600;
   localparam logic [PER_W-1:0] PERIOD_RESET = 8'd10;
   // quotient widths seen by the shared divider
   localparam logic [STEP_W-1:0] STEPS_AVG = 6'd40;
   localparam logic [STEP_W-1:0] STEPS_RSI = 6'd15;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic               restart;
   } req_payload_type;

   typedef struct packed {
      logic [RSI_W-1:0] rsi_value;
      logic             rsi_valid;
   } rsp_payload_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  rem_init;
      logic [QUO_W-1:0]  work_init;
      logic [STEP_W-1:0] steps;
      logic [DIV_W-1:0]  divisor;
   } div_cmd_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_stat_type;

   typedef struct packed {
      logic             idle;
      logic             done;
      logic [RSI_W-1:0] rsi_value;
      logic             rsi_valid;
   } seq_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DELTA,
      ST_ACCUM,
      ST_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_CHECK,
      ST_RSI_START,
      ST_RSI_WAIT,
      ST_DONE
   } seq_state_type;

endpackage

/* rtl/core/relative_strength_index_unit.sv */
// relative_strength_index_unit: streaming Wilder RSI over Q16.16 prices
// holds the period register and the result register; depends on rsi_pkg,
// rsi_sequencer and rsi_divider
//
//   channel  | ports                                  | direction
//   ---------+----------------------------------------+----------
//   request  | req_valid, req_stall, req_payload      | in
//   response | rsp_valid, rsp_stall, rsp_payload      | out
//   csr      | csr_write_enable, csr_write_data       | in
//
// one transaction at a time. a first price or a warm-up change runs no divide;
// the end of warm-up or a smoothed change runs two average divides and then a
// ratio divide, skipped when the average loss is zero, on the shared divider
// at one bit per cycle (40 quotient bits per average, 15 for the ratio). reset
// is synchronous and clears the series state and period (back to 10). a result
// waits in the output register; a stalled output holds the sequencer at its end.
module relative_strength_index_unit #(
   parameter int PERIOD_MAX = 255
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  rsi_pkg::req_payload_type     req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output rsi_pkg::rsp_payload_type     rsp_payload,
   input  logic                         csr_write_enable,
   input  logic [rsi_pkg::PER_W-1:0]    csr_write_data
);

   localparam int PMAX_CLIP = (PERIOD_MAX > 255) ? 255 : PERIOD_MAX;
   localparam logic [rsi_pkg::PER_W-1:0] PMAX = rsi_pkg::PER_W'(PMAX_CLIP);

   logic [rsi_pkg::PER_W-1:0]   period_ff, period_in;
   logic [rsi_pkg::PER_W-1:0]   period_n;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsi_pkg::rsp_payload_type    rsp_payload_ff, rsp_payload_in;
   logic                        start;
   logic                        slot_free;
   rsi_pkg::div_cmd_type        div_cmd;
   rsi_pkg::div_stat_type       div_stat;
   rsi_pkg::seq_stat_type       seq_stat;

   // period register and its clamp to 1..PERIOD_MAX
   assign period_in = csr_write_enable ? csr_write_data : period_ff;
   assign period_n  = (period_ff == '0) ? rsi_pkg::PER_W'(1) :
                      ((period_ff > PMAX) ? PMAX : period_ff);

   // request handshake
   assign req_stall = !seq_stat.idle;
   assign start     = req_valid && !req_stall;

   // output register
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (seq_stat.done && slot_free) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.rsi_value = seq_stat.rsi_value;
         rsp_payload_in.rsi_valid = seq_stat.rsi_valid;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= rsi_pkg::PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   rsi_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_payload),
      .period    (period_n),
      .slot_free (slot_free),
      .div_cmd   (div_cmd),
      .div_stat  (div_stat),
      .stat      (seq_stat)
   );

   rsi_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

endmodule

/* rtl/core/rsi_divider.sv */
// rsi_divider: shared restoring divider, one quotient bit per cycle
// the caller preloads the partial remainder and the left-aligned dividend bits
// depends on rsi_pkg
module rsi_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  rsi_pkg::div_cmd_type cmd,
   output rsi_pkg::div_stat_type stat
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [rsi_pkg::STEP_W-1:0]  cnt_ff, cnt_in;
   logic [rsi_pkg::DIV_W-1:0]   rem_ff, rem_in;
   logic [rsi_pkg::QUO_W-1:0]   work_ff, work_in;
   logic [rsi_pkg::DIV_W-1:0]   div_ff, div_in;

   logic [rsi_pkg::DIV_W:0]     shifted;
   logic [rsi_pkg::DIV_W+1:0]   diff;
   logic                        neg;

   // trial subtract of the divisor from the shifted remainder
   assign shifted = {rem_ff, work_ff[rsi_pkg::QUO_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, div_ff};
   assign neg     = diff[rsi_pkg::DIV_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      work_in = work_ff;
      div_in  = div_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.steps;
         rem_in  = cmd.rem_init;
         work_in = cmd.work_init;
         div_in  = cmd.divisor;
      end else if (busy_ff) begin
         rem_in  = neg ? shifted[rsi_pkg::DIV_W-1:0] : diff[rsi_pkg::DIV_W-1:0];
         work_in = {work_ff[rsi_pkg::QUO_W-2:0], ~neg};
         cnt_in  = cnt_ff - 1'b1;
         // last quotient bit
         if (cnt_ff == rsi_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      work_ff <= work_in;
      div_ff  <= div_in;
   end

   assign stat.done     = done_ff;
   assign stat.quotient = work_ff;

endmodule

/* rtl/core/rsi_sequencer.sv */
// rsi_sequencer: series state, shared multiplier and the control sequence
// drives the shared divider for the averages and the final ratio
// depends on rsi_pkg
module rsi_sequencer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  rsi_pkg::req_payload_type     req,
   input  logic [rsi_pkg::PER_W-1:0]    period,
   input  logic                         slot_free,
   output rsi_pkg::div_cmd_type         div_cmd,
   input  rsi_pkg::div_stat_type        div_stat,
   output rsi_pkg::seq_stat_type        stat
);

   localparam int AW = rsi_pkg::AVG_W;
   localparam int QW = rsi_pkg::QUO_W;
   localparam int PW = rsi_pkg::PRICE_W;

   rsi_pkg::seq_state_type state_ff, state_in;

   logic [PW-1:0]                price_ff, price_in;
   logic                         restart_ff, restart_in;
   logic [PW-1:0]                last_ff, last_in;
   logic                         have_ff, have_in;
   logic [rsi_pkg::PER_W-1:0]    count_ff, count_in;
   logic [AW-1:0]                gain_avg_ff, gain_avg_in;
   logic [AW-1:0]                loss_avg_ff, loss_avg_in;
   logic [PW-1:0]                gain_ff, gain_in;
   logic [PW-1:0]                loss_ff, loss_in;
   logic                         sel_loss_ff, sel_loss_in;
   logic                         smooth_ff, smooth_in;
   logic [rsi_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [rsi_pkg::DIV_W-1:0]    total_ff, total_in;
   logic [rsi_pkg::RSI_W-1:0]    res_value_ff, res_value_in;
   logic                         res_valid_ff, res_valid_in;

   logic [AW-1:0]                mul_a;
   logic [rsi_pkg::RSI_W-1:0]    mul_b;
   logic [rsi_pkg::PROD_W-1:0]   mul_p;
   logic [rsi_pkg::PER_W-1:0]    count_nx;
   logic [AW-1:0]                sel_avg;
   logic [PW-1:0]                sel_x;
   logic [AW-1:0]                dividend;
   logic                         new_series;

   // shared multiplier
   assign mul_p = mul_a * mul_b;

   assign count_nx   = count_ff + 1'b1;
   assign sel_avg    = sel_loss_ff ? loss_avg_ff : gain_avg_ff;
   assign sel_x      = sel_loss_ff ? loss_ff : gain_ff;
   assign new_series = restart_ff || !have_ff;
   assign dividend   = smooth_ff ? (prod_ff[AW-1:0] + {{(AW-PW){1'b0}}, sel_x}) : sel_avg;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rsi_pkg::ST_IDLE: begin
            if (start) state_in = rsi_pkg::ST_DELTA;
         end
         rsi_pkg::ST_DELTA: begin
            state_in = new_series ? rsi_pkg::ST_DONE : rsi_pkg::ST_ACCUM;
         end
         rsi_pkg::ST_ACCUM: begin
            if (count_ff == rsi_pkg::COUNT_DONE) state_in = rsi_pkg::ST_MUL;
            else if (count_nx >= period)         state_in = rsi_pkg::ST_DIV_START;
            else                                 state_in = rsi_pkg::ST_DONE;
         end
         rsi_pkg::ST_MUL:       state_in = rsi_pkg::ST_DIV_START;
         rsi_pkg::ST_DIV_START: state_in = rsi_pkg::ST_DIV_WAIT;
         rsi_pkg::ST_DIV_WAIT: begin
            if (div_stat.done) begin
               if (sel_loss_ff) state_in = rsi_pkg::ST_CHECK;
               else state_in = smooth_ff ? rsi_pkg::ST_MUL : rsi_pkg::ST_DIV_START;
            end
         end
         rsi_pkg::ST_CHECK: begin
            state_in = (loss_avg_ff == '0) ? rsi_pkg::ST_DONE : rsi_pkg::ST_RSI_START;
         end
         rsi_pkg::ST_RSI_START: state_in = rsi_pkg::ST_RSI_WAIT;
         rsi_pkg::ST_RSI_WAIT: begin
            if (div_stat.done) state_in = rsi_pkg::ST_DONE;
         end
         rsi_pkg::ST_DONE: begin
            if (slot_free) state_in = rsi_pkg::ST_IDLE;
         end
         default: state_in = rsi_pkg::ST_IDLE;
      endcase
   end

   // datapath and divider commands per state
   always_comb begin
      price_in     = price_ff;
      restart_in   = restart_ff;
      last_in      = last_ff;
      have_in      = have_ff;
      count_in     = count_ff;
      gain_avg_in  = gain_avg_ff;
      loss_avg_in  = loss_avg_ff;
      gain_in      = gain_ff;
      loss_in      = loss_ff;
      sel_loss_in  = sel_loss_ff;
      smooth_in    = smooth_ff;
      prod_in      = prod_ff;
      total_in     = total_ff;
      res_value_in = res_value_ff;
      res_valid_in = res_valid_ff;
      mul_a        = gain_avg_ff;
      mul_b        = '0;
      div_cmd      = '0;
      case (state_ff)
         rsi_pkg::ST_IDLE: begin
            if (start) begin
               price_in     = req.price;
               restart_in   = req.restart;
               res_value_in = '0;
               res_valid_in = 1'b0;
               sel_loss_in  = 1'b0;
            end
         end
         rsi_pkg::ST_DELTA: begin
            last_in = price_ff;
            if (new_series) begin
               have_in     = 1'b1;
               count_in    = '0;
               gain_avg_in = '0;
               loss_avg_in = '0;
            end else if (price_ff > last_ff) begin
               gain_in = price_ff - last_ff;
               loss_in = '0;
            end else begin
               gain_in = '0;
               loss_in = last_ff - price_ff;
            end
         end
         rsi_pkg::ST_ACCUM: begin
            // warm-up sums, or mark smoothing
            if (count_ff != rsi_pkg::COUNT_DONE) begin
               gain_avg_in = gain_avg_ff + {{(AW-PW){1'b0}}, gain_ff};
               loss_avg_in = loss_avg_ff + {{(AW-PW){1'b0}}, loss_ff};
               smooth_in   = 1'b0;
               count_in    = (count_nx >= period) ? rsi_pkg::COUNT_DONE : count_nx;
            end else begin
               smooth_in = 1'b1;
            end
         end
         rsi_pkg::ST_MUL: begin
            // avg * (n - 1)
            mul_a   = sel_avg;
            mul_b   = {{(rsi_pkg::RSI_W-rsi_pkg::PER_W){1'b0}}, period - 1'b1};
            prod_in = mul_p;
         end
         rsi_pkg::ST_DIV_START: begin
            div_cmd.start     = 1'b1;
            div_cmd.rem_init  = {{(rsi_pkg::DIV_W-(AW-QW)){1'b0}}, dividend[AW-1:QW]};
            div_cmd.work_init = dividend[QW-1:0];
            div_cmd.steps     = rsi_pkg::STEPS_AVG;
            div_cmd.divisor   = {{(rsi_pkg::DIV_W-rsi_pkg::PER_W){1'b0}}, period};
         end
         rsi_pkg::ST_DIV_WAIT: begin
            if (div_stat.done) begin
               if (sel_loss_ff) loss_avg_in = {{(AW-QW){1'b0}}, div_stat.quotient};
               else             gain_avg_in = {{(AW-QW){1'b0}}, div_stat.quotient};
               sel_loss_in = 1'b1;
            end
         end
         rsi_pkg::ST_CHECK: begin
            // 25600 * gain and gain + loss
            mul_a    = gain_avg_ff;
            mul_b    = rsi_pkg::RSI_SCALE;
            prod_in  = mul_p;
            total_in = {1'b0, gain_avg_ff} + {1'b0, loss_avg_ff};
         end
         rsi_pkg::ST_RSI_START: begin
            // quotient stays below 2^15, so the top bits start as the remainder
            div_cmd.start     = 1'b1;
            div_cmd.rem_init  = {1'b0, prod_ff[rsi_pkg::PROD_W-1:rsi_pkg::RSI_W]};
            div_cmd.work_init = {prod_ff[rsi_pkg::RSI_W-1:0], {(QW-rsi_pkg::RSI_W){1'b0}}};
            div_cmd.steps     = rsi_pkg::STEPS_RSI;
            div_cmd.divisor   = total_ff;
         end
         rsi_pkg::ST_RSI_WAIT: begin
            if (div_stat.done) begin
               res_value_in = div_stat.quotient[rsi_pkg::RSI_W-1:0];
               res_valid_in = 1'b1;
            end
         end
         rsi_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= rsi_pkg::ST_IDLE;
         last_ff     <= '0;
         have_ff     <= 1'b0;
         count_ff    <= '0;
         gain_avg_ff <= '0;
         loss_avg_ff <= '0;
         sel_loss_ff <= 1'b0;
         smooth_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         last_ff     <= last_in;
         have_ff     <= have_in;
         count_ff    <= count_in;
         gain_avg_ff <= gain_avg_in;
         loss_avg_ff <= loss_avg_in;
         sel_loss_ff <= sel_loss_in;
         smooth_ff   <= smooth_in;
      end
      price_ff     <= price_in;
      restart_ff   <= restart_in;
      gain_ff      <= gain_in;
      loss_ff      <= loss_in;
      prod_ff      <= prod_in;
      total_ff     <= total_in;
      res_value_ff <= res_value_in;
      res_valid_ff <= res_valid_in;
   end

   assign stat.idle      = (state_ff == rsi_pkg::ST_IDLE);
   assign stat.done      = (state_ff == rsi_pkg::ST_DONE);
   assign stat.rsi_value = res_value_ff;
   assign stat.rsi_valid = res_valid_ff;

endmodule

/* rtl/core/rsi_checker.sv */
// rsi_checker: port-level assertions for relative_strength_index_unit
// bound to the top level below; depends on rsi_pkg
module rsi_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input rsi_pkg::req_payload_type     req_payload,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input rsi_pkg::rsp_payload_type     rsp_payload,
   input logic                         csr_write_enable,
   input logic [rsi_pkg::PER_W-1:0]    csr_write_data
);

   // a stalled response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // an invalid rsi carries a zero value
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.rsi_valid |-> rsp_payload.rsi_value == '0)
      else $error("invalid rsi with nonzero value");

   // rsi never above 100.0
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.rsi_value <= rsi_pkg::RSI_SCALE)
      else $error("rsi above full scale");

   // one transaction at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

endmodule

bind relative_strength_index_unit rsi_checker u_rsi_checker (.*);
